[hdl/mbet_pkg.sv]
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared constants and payload types for the escape-time block.
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 28;
  localparam int CountWidth = 16;

  localparam int LimitWidth  = 16;
  localparam int RadiusWidth = 31;
  localparam int AddrWidth   = 3;

  localparam logic [AddrWidth-1:0] RegLimitAddr  = 3'h0;
  localparam logic [AddrWidth-1:0] RegRadiusAddr = 3'h4;

  localparam logic [LimitWidth-1:0]  LimitReset  = 16'd256;
  localparam logic [RadiusWidth-1:0] RadiusReset = 31'd536870912;

  typedef struct packed {
    logic                         last_point;
    logic signed [CoordWidth-1:0] c_imag;
    logic signed [CoordWidth-1:0] c_real;
  } in_item_t;

  typedef struct packed {
    logic                  last_result;
    logic                  escaped;
    logic [CountWidth-1:0] iteration_count;
  } out_item_t;

endpackage

[hdl/mbet_ram.sv]
// ----------------------------------------------------------------------------
// mbet_ram
// Generic RAM with separate write and read ports and a registered read.
// ----------------------------------------------------------------------------
module mbet_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/mbet_core.sv]
// ----------------------------------------------------------------------------
// mbet_core
// Iteration sequencer. z lives in a RAM; each iteration reads z, squares it
// in the multiply and sum steps, tests escape and writes back the new z.
// ----------------------------------------------------------------------------
module mbet_core import mbet_pkg::*; #(
  parameter int FracW  = FracBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [LimitWidth-1:0]  limit_i,
  input  logic [RadiusWidth-1:0] radius_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [CoordWidth-1:0] c_real_i,
  input  logic signed [CoordWidth-1:0] c_imag_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CountWidth-1:0]  count_o,
  output logic                   escaped_o,
  output logic                   last_o
);

  localparam int PW = 2 * CoordWidth + 2;
  localparam int LW = (LimitWidth > CountWidth) ? LimitWidth : CountWidth;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StWb   = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [CountWidth-1:0] it_q, lim_q;
  logic signed [CoordWidth-1:0] cr_q, ci_q;
  logic last_q, esc_q;
  logic [2*RadiusWidth-1:0] r2_q;

  // output register, frees the sequencer while a result waits
  logic out_valid_q;
  logic [CountWidth-1:0] cnt_out_q;
  logic esc_out_q, last_out_q;
  logic out_load;

  // z memory: one entry holds {zr, zi}
  logic we;
  logic [2*CoordWidth-1:0] wdata, rdata;
  mbet_ram #(.Width(2*CoordWidth), .Depth(2)) u_zram (
    .clk_i, .we_i(we), .waddr_i(1'b0), .wdata_i(wdata),
    .raddr_i(1'b0), .rdata_o(rdata)
  );

  logic signed [CoordWidth-1:0] zr, zi;
  assign zr = rdata[2*CoordWidth-1:CoordWidth];
  assign zi = rdata[CoordWidth-1:0];

  logic signed [2*CoordWidth-1:0] sr_q, si_q, sx_q;
  logic signed [PW-1:0] mag_q, dr_q;

  // saturate a wide value to the coordinate range
  function automatic logic [CoordWidth-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] mx, mn;
    mx = PW'({1'b0, {(CoordWidth-1){1'b1}}});
    mn = -mx - PW'(1);
    if (v > mx) sat = mx[CoordWidth-1:0];
    else if (v < mn) sat = mn[CoordWidth-1:0];
    else sat = v[CoordWidth-1:0];
  endfunction

  logic signed [PW-1:0] nr, ni;
  assign nr = (dr_q >>> FracW) + PW'(cr_q);
  assign ni = (PW'(sx_q) >>> (FracW - 1)) + PW'(ci_q);

  logic [LW-1:0] lim_ext;
  assign lim_ext = LW'(limit_i);

  logic [LW-1:0] cmax;
  assign cmax = LW'({CountWidth{1'b1}});

  logic escape;
  assign escape = mag_q > PW'(r2_q);

  // finished point moves to the output register when it is free
  assign out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    wdata = {nr[CoordWidth-1:0], ni[CoordWidth-1:0]};
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        we = 1'b1;
        wdata = '0;
        state_d = StRead;
      end
      StRead: state_d = (it_q == lim_q) ? StOut : StMul;
      StMul: state_d = StSum;
      StSum: state_d = StWb;
      StWb: begin
        if (escape) state_d = StOut;
        else begin
          we = 1'b1;
          wdata = {sat(nr), sat(ni)};
          state_d = StRead;
        end
      end
      StOut: if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      cr_q <= c_real_i;
      ci_q <= c_imag_i;
      last_q <= last_i;
      it_q <= '0;
      esc_q <= 1'b0;
      lim_q <= (lim_ext > cmax) ? cmax[CountWidth-1:0] : lim_ext[CountWidth-1:0];
      r2_q <= radius_i * radius_i;
    end
    if (state_q == StMul) begin
      sr_q <= zr * zr;
      si_q <= zi * zi;
      sx_q <= zr * zi;
    end
    if (state_q == StSum) begin
      mag_q <= PW'(sr_q) + PW'(si_q);
      dr_q <= PW'(sr_q) - PW'(si_q);
    end
    if (state_q == StWb) begin
      if (escape) esc_q <= 1'b1;
      else it_q <= it_q + 1'b1;
    end
    if (out_load) begin
      cnt_out_q  <= it_q;
      esc_out_q  <= esc_q;
      last_out_q <= last_q;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign count_o     = cnt_out_q;
  assign escaped_o   = esc_out_q;
  assign last_o      = last_out_q;

`ifndef SYNTHESIS
  a_wait_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && out_valid_o && !out_ready_i) |=> state_q == StOut)
    else $error("finished point left while output full");
  a_cnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= lim_q)) else $error("count over limit");
  a_no_esc_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !escaped_o) |-> (count_o == lim_q))
    else $error("unescaped count differs from limit");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(count_o))
    else $error("result dropped");
`endif

endmodule

[hdl/mandelbrot_escape_time.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time counter for one point per transfer.
// ----------------------------------------------------------------------------
// Usage: send a point c on the input channel (valid/ready). The block
// iterates z = z*z + c from z = 0 and returns one result transfer with the
// iteration count, escaped flag and echoed last marker.
// Each iteration steps through z RAM read, multiply, sum and write back.
// The result sits in an output register, so the block returns to idle and
// accepts the next point while the result waits; a new point is taken only
// once the last one has finished iterating. A stalled receiver holds the
// output register; the next finished point then waits for it to free up.
// Config: APB, reg 0 iteration_limit at 0x0, reg 1 radius at 0x4, to be
// written only while idle by the user; the block does not enforce this.
// Reset restores limit 256, radius 2.0 and returns to idle; the z RAM
// needs no clearing, it is written per point.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbet_pkg::*; #(
  parameter int FracW  = FracBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  logic [LimitWidth-1:0]  limit_q;
  logic [RadiusWidth-1:0] radius_q;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LimitReset;
      radius_q <= RadiusReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegLimitAddr:  limit_q  <= pwdata[LimitWidth-1:0];
        RegRadiusAddr: radius_q <= pwdata[RadiusWidth-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr)
      RegLimitAddr:  prdata = 32'(limit_q);
      RegRadiusAddr: prdata = 32'(radius_q);
      default:       prdata = '0;
    endcase
  end

  mbet_core #(.FracW(FracW)) u_core (
    .clk_i, .rst_ni,
    .limit_i(limit_q), .radius_i(radius_q),
    .in_valid_i, .in_ready_o,
    .c_real_i(in_data_i.c_real), .c_imag_i(in_data_i.c_imag),
    .last_i(in_data_i.last_point),
    .out_valid_o, .out_ready_i,
    .count_o(out_data_o.iteration_count),
    .escaped_o(out_data_o.escaped),
    .last_o(out_data_o.last_result)
  );

endmodule
